>>> rtl/assert_macros.svh
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked while out of reset
`define PRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included
`define PRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/prc_pkg.sv
package prc_pkg;

  localparam int RowW  = 12;
  localparam int SampW = 16;
  localparam int ProdW = 2 * SampW;
  localparam int VarW  = 31;
  localparam int SumW  = 48;
  localparam int CcW   = 13;
  localparam int StW   = 2;
  localparam int AddrW = 4;
  localparam int DataW = 32;

  localparam logic [CcW-1:0]   MAX_COLUMNS = 13'd4096;
  localparam logic [SampW-1:0] Q15_ONE     = 16'h7FFF;

  // register byte addresses
  localparam logic [AddrW-1:0] ADDR_REF_ROW   = 4'h0;
  localparam logic [AddrW-1:0] ADDR_COL_COUNT = 4'h4;
  localparam logic [AddrW-1:0] ADDR_REF_VAR   = 4'h8;

  typedef enum logic [StW-1:0] {
    ST_NORMAL = 2'd0,
    ST_SELF   = 2'd1,
    ST_UNDEF  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_VMUL,
    BK_SQRT,
    BK_DMUL,
    BK_DIV,
    BK_SAT,
    BK_OUT
  } bk_state_e;

  // one finished row handed from front to back
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [SumW-1:0] sum;
    logic [VarW-1:0] rvar;
  } job_t;

  typedef struct packed {
    logic [RowW-1:0] ref_row;
    logic [CcW-1:0]  column_count;
    logic [VarW-1:0] ref_variance;
  } cfg_t;

endpackage

>>> rtl/prc_in_if.sv
interface prc_in_if;
  logic                               valid;
  logic                               ready;
  logic [prc_pkg::RowW-1:0]           row_index;
  logic signed [prc_pkg::SampW-1:0]   x_sample;
  logic signed [prc_pkg::SampW-1:0]   y_sample;
  logic [prc_pkg::VarW-1:0]           row_variance;
  logic                               last_sample;

  modport source (output valid, row_index, x_sample, y_sample, row_variance, last_sample,
                  input ready);
  modport sink (input valid, row_index, x_sample, y_sample, row_variance, last_sample,
                output ready);
endinterface

>>> rtl/prc_out_if.sv
interface prc_out_if;
  logic                               valid;
  logic                               ready;
  logic [prc_pkg::RowW-1:0]           out_row;
  logic signed [prc_pkg::SampW-1:0]   coefficient;
  logic [prc_pkg::StW-1:0]            status;

  modport source (output valid, out_row, coefficient, status, input ready);
  modport sink (input valid, out_row, coefficient, status, output ready);
endinterface

>>> rtl/prc_front.sv
module prc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  prc_in_if.sink         in_i,
  output prc_pkg::job_t  job_o,
  output logic           job_valid_o,
  input  logic           job_ready_i
);

  logic                            s1_valid_q;
  logic signed [prc_pkg::ProdW-1:0] prod_q;
  logic [prc_pkg::RowW-1:0]        row_q;
  logic [prc_pkg::VarW-1:0]        rvar_q;
  logic                            last_q;
  logic [prc_pkg::SumW-1:0]        sum_q;
  logic [prc_pkg::SumW-1:0]        sum_next;
  logic                            advance;
  logic                            take;

  // stage 1 moves unless a row end waits on a full queue
  assign advance     = !s1_valid_q || !last_q || job_ready_i;
  assign in_i.ready  = advance;
  assign take        = in_i.valid && advance;
  assign sum_next    = sum_q + {{(prc_pkg::SumW-prc_pkg::ProdW){prod_q[prc_pkg::ProdW-1]}},
                                prod_q};
  assign job_valid_o = s1_valid_q && last_q;
  assign job_o       = '{row: row_q, sum: sum_next, rvar: rvar_q};

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q <= in_i.x_sample * in_i.y_sample;
      row_q  <= in_i.row_index;
      rvar_q <= in_i.row_variance;
      last_q <= in_i.last_sample;
    end
  end

  // accumulator, cleared at every row end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_valid_q && advance) begin
      sum_q <= last_q ? '0 : sum_next;
    end
  end

endmodule

>>> rtl/prc_queue.sv
module prc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  prc_pkg::job_t  push_data_i,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  output prc_pkg::job_t  pop_data_o,
  output logic           pop_valid_o,
  input  logic           pop_ready_i
);

  prc_pkg::job_t entry_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q;
  logic          push;
  logic          pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/prc_back.sv
`include "assert_macros.svh"

module prc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  prc_pkg::cfg_t  cfg_i,
  input  prc_pkg::job_t  job_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  prc_out_if.source      out_o
);

  prc_pkg::bk_state_e state_q, state_d;

  logic [prc_pkg::RowW-1:0]  row_q;
  logic                      neg_q;
  logic [prc_pkg::SumW-1:0]  mag_q;
  logic [prc_pkg::VarW-1:0]  rvar_q;
  logic [61:0]               p_q;
  logic [63:0]               r_q;
  logic [5:0]                cnt_q;
  logic [43:0]               den2_q;
  logic [63:0]               num_q;
  logic [43:0]               rem_q;
  logic [16:0]               quo_q;
  logic                      ovf_q;
  logic [prc_pkg::SampW-1:0] coef_q;
  prc_pkg::status_e          status_q;

  logic                      pop;
  logic                      self_row;
  logic                      few_cols;
  logic [63:0]               sq_bit;
  logic [63:0]               sq_trial;
  logic                      sq_ge;
  logic [prc_pkg::CcW-1:0]   n_eff;
  logic [11:0]               nm1;
  logic [43:0]               den;
  logic [44:0]               dv_t;
  logic                      dv_ge;
  logic [44:0]               dv_diff;
  logic                      q_big;

  assign pop      = job_valid_i && job_ready_o;
  assign self_row = (job_i.row == cfg_i.ref_row);
  assign few_cols = (cfg_i.column_count < prc_pkg::CcW'(2));

  // root step: one result bit per cycle
  assign sq_bit   = 64'd1 << {cnt_q[4:0], 1'b0};
  assign sq_trial = r_q + sq_bit;
  assign sq_ge    = ({2'b00, p_q} >= sq_trial);

  // denominator (n-1)*root
  assign n_eff = (cfg_i.column_count > prc_pkg::MAX_COLUMNS) ? prc_pkg::MAX_COLUMNS
                                                             : cfg_i.column_count;
  assign nm1   = 12'(n_eff - prc_pkg::CcW'(1));
  assign den   = {32'd0, nm1} * {12'd0, r_q[31:0]};

  // restoring division step
  assign dv_t    = {rem_q, num_q[63]};
  assign dv_ge   = (dv_t >= {1'b0, den2_q});
  assign dv_diff = dv_t - {1'b0, den2_q};

  assign q_big = neg_q ? (ovf_q || quo_q > 17'd32768) : (ovf_q || quo_q > 17'd32767);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      prc_pkg::BK_IDLE: begin
        if (pop) state_d = (self_row || few_cols) ? prc_pkg::BK_OUT : prc_pkg::BK_VMUL;
      end
      prc_pkg::BK_VMUL: state_d = prc_pkg::BK_SQRT;
      prc_pkg::BK_SQRT: begin
        if (cnt_q == 6'd0) state_d = prc_pkg::BK_DMUL;
      end
      prc_pkg::BK_DMUL: state_d = (den == '0) ? prc_pkg::BK_OUT : prc_pkg::BK_DIV;
      prc_pkg::BK_DIV: begin
        if (cnt_q == 6'd0) state_d = prc_pkg::BK_SAT;
      end
      prc_pkg::BK_SAT:  state_d = prc_pkg::BK_OUT;
      prc_pkg::BK_OUT: begin
        if (out_o.ready) state_d = prc_pkg::BK_IDLE;
      end
      default: state_d = prc_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_ready_o       = (state_q == prc_pkg::BK_IDLE);
    out_o.valid       = (state_q == prc_pkg::BK_OUT);
    out_o.out_row     = row_q;
    out_o.coefficient = coef_q;
    out_o.status      = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prc_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      prc_pkg::BK_IDLE: begin
        if (pop) begin
          row_q  <= job_i.row;
          neg_q  <= job_i.sum[prc_pkg::SumW-1];
          mag_q  <= job_i.sum[prc_pkg::SumW-1] ? (~job_i.sum + 48'd1) : job_i.sum;
          rvar_q <= job_i.rvar;
          coef_q <= self_row ? prc_pkg::Q15_ONE : '0;
          status_q <= self_row ? prc_pkg::ST_SELF : prc_pkg::ST_UNDEF;
        end
      end
      prc_pkg::BK_VMUL: begin
        p_q   <= {31'd0, cfg_i.ref_variance} * {31'd0, rvar_q};
        r_q   <= '0;
        cnt_q <= 6'd31;
      end
      prc_pkg::BK_SQRT: begin
        if (sq_ge) begin
          p_q <= 62'({2'b00, p_q} - sq_trial);
          r_q <= (r_q >> 1) + sq_bit;
        end else begin
          r_q <= r_q >> 1;
        end
        cnt_q <= cnt_q - 6'd1;
      end
      prc_pkg::BK_DMUL: begin
        den2_q <= {den[42:0], 1'b0};
        num_q  <= {mag_q, 16'd0} + {20'd0, den};
        rem_q  <= '0;
        quo_q  <= '0;
        ovf_q  <= 1'b0;
        cnt_q  <= 6'd63;
      end
      prc_pkg::BK_DIV: begin
        rem_q <= dv_ge ? dv_diff[43:0] : dv_t[43:0];
        quo_q <= {quo_q[15:0], dv_ge};
        ovf_q <= ovf_q | quo_q[16];
        num_q <= {num_q[62:0], 1'b0};
        cnt_q <= cnt_q - 6'd1;
      end
      prc_pkg::BK_SAT: begin
        status_q <= prc_pkg::ST_NORMAL;
        if (neg_q) begin
          coef_q <= q_big ? 16'h8000 : 16'(~quo_q + 17'd1);
        end else begin
          coef_q <= q_big ? prc_pkg::Q15_ONE : quo_q[15:0];
        end
      end
      default: ;
    endcase
  end

  `PRC_ASSERT(a_pop_leaves_idle, pop |=> state_q != prc_pkg::BK_IDLE, "job taken but idle")
  `PRC_ASSERT(a_status_code, out_o.valid |-> out_o.status != 2'd3, "bad status code")
  `PRC_ASSERT(a_self_one,
    (out_o.valid && out_o.status == prc_pkg::ST_SELF) |-> out_o.coefficient == prc_pkg::Q15_ONE,
    "self row not one")
  `PRC_ASSERT_ALWAYS(a_no_take_busy, !rst_ni || !(job_ready_o && out_o.valid),
    "takes job while result waits")

endmodule

>>> rtl/pearson_row_correlation_top.sv
// Samples: one pair per cycle; input stalls only while a row end finds the job queue full.
// After the last pair is taken, a result passes the product register and queue write, the job take,
// the variance multiply, 32 root steps, the denominator multiply, 64 divide steps and saturation;
// a self row or too few columns goes straight to the output, and a zero denominator skips the division.
// Back unit takes a new row only after its result is taken; two row ends can wait in the queue.
// Reset is asynchronous, active low: clears accumulator, queue, control; ref_row 0, column_count 2, ref_variance 0.
module pearson_row_correlation_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prc_pkg::AddrW-1:0]     paddr,
  input  logic [prc_pkg::DataW-1:0]     pwdata,
  output logic [prc_pkg::DataW-1:0]     prdata,
  output logic                          pready,
  prc_in_if.sink                        in_i,
  prc_out_if.source                     out_o
);

  prc_pkg::cfg_t cfg_q;
  prc_pkg::job_t f_job, q_job;
  logic          f_valid, f_ready, q_valid, q_ready;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_row      <= '0;
      cfg_q.column_count <= prc_pkg::CcW'(2);
      cfg_q.ref_variance <= '0;
    end else if (wr_en) begin
      case (paddr)
        prc_pkg::ADDR_REF_ROW:   cfg_q.ref_row      <= pwdata[prc_pkg::RowW-1:0];
        prc_pkg::ADDR_COL_COUNT: cfg_q.column_count <= pwdata[prc_pkg::CcW-1:0];
        prc_pkg::ADDR_REF_VAR:   cfg_q.ref_variance <= pwdata[prc_pkg::VarW-1:0];
        default: ;
      endcase
    end
  end

  // read-back
  always_comb begin
    case (paddr)
      prc_pkg::ADDR_REF_ROW:   prdata = 32'(cfg_q.ref_row);
      prc_pkg::ADDR_COL_COUNT: prdata = 32'(cfg_q.column_count);
      prc_pkg::ADDR_REF_VAR:   prdata = 32'(cfg_q.ref_variance);
      default:                 prdata = '0;
    endcase
  end

  prc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (f_job),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready)
  );

  prc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (f_job),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_data_o   (q_job),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  prc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .out_o       (out_o)
  );

endmodule
